// ===== hw/rtl/ntps_pkg.sv =====
// Shared types, constants and helpers for the nearest trajectory point search block.
package ntps_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int JOINTS_DEF      = 7;
    localparam int SAMPLE_BITS_DEF = 20;

    localparam int ENTRY_COUNT_W = 11;
    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;
    localparam int ACC_W         = 64;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [9:0]        entry_index;
        logic [2:0]        joint_index;
        logic signed [19:0] mean_value;
        logic [18:0]       std_value;
        logic signed [19:0] angle_0;
        logic signed [19:0] angle_1;
        logic signed [19:0] angle_2;
        logic signed [19:0] angle_3;
        logic signed [19:0] angle_4;
        logic signed [19:0] angle_5;
        logic signed [19:0] angle_6;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         result_joint;
        logic signed [19:0] nearest_mean;
        logic [18:0]        nearest_std;
        logic [9:0]         match_index;
        logic               empty_table;
        logic               last_of_run;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic first_joint;
        logic last_joint;
        logic first_row;
        logic last_row;
    } scan_tag_t;

    typedef struct packed {
        logic valid;
        logic empty;
        logic last;
    } emit_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    // Sign-extend a 20-bit field to 32 bits.
    function automatic logic [31:0] sext20(input logic [19:0] v);
        sext20 = 32'($signed(v));
    endfunction

endpackage

// ===== hw/rtl/ntps_store.sv =====
// Mean and spread memories: one write port, one registered read port.
module ntps_store
    import ntps_pkg::*;
#(
    parameter int DEPTH       = MAX_ENTRIES_DEF * JOINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_mean,
    input  logic [SAMPLE_BITS-1:0] wr_spread,
    input  logic [AW-1:0]          rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_mean,
    output logic [SAMPLE_BITS-1:0] rd_spread
);

    logic [SAMPLE_BITS-1:0] mean_mem   [DEPTH];
    logic [SAMPLE_BITS-1:0] spread_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mean_mem[wr_addr]   <= wr_mean;
            spread_mem[wr_addr] <= wr_spread;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_mean   <= mean_mem[rd_addr];
        rd_spread <= spread_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/ntps_dist_unit.sv =====
// Shared subtract, square and accumulate unit with running minimum tracking.
module ntps_dist_unit
    import ntps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int JOINTS      = JOINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int JW         = (JOINTS > 1) ? $clog2(JOINTS) : 1
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_load,
    input  logic [JOINTS-1:0][SAMPLE_BITS-1:0] query,
    input  scan_tag_t                          scan_tag,
    input  logic [IW-1:0]                      scan_row,
    input  logic [JW-1:0]                      scan_joint,
    input  logic [SAMPLE_BITS-1:0]             rd_mean,
    output logic [IW-1:0]                      best_idx,
    output logic                               best_done
);

    logic [JOINTS-1:0][SAMPLE_BITS-1:0] q_reg;

    scan_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic [IW-1:0] row1_reg, row2_reg, row3_reg, row4_reg;
    logic [JW-1:0] joint1_reg;

    logic [SAMPLE_BITS-1:0]   mag2_reg;
    logic [2*SAMPLE_BITS-1:0] sq3_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     row_done4_reg;
    logic                     first_row4_reg;
    logic                     last_row4_reg;
    logic [ACC_W-1:0]         best_dist_reg;
    logic [IW-1:0]            best_idx_reg;
    logic                     done5_reg;

    logic [SAMPLE_BITS-1:0] q_sel;
    logic [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]   mag_wide;
    logic [ACC_W:0]         sum;
    logic [ACC_W-1:0]       acc_next;

    assign q_sel    = q_reg[joint1_reg];
    assign diff     = {rd_mean[SAMPLE_BITS-1], rd_mean} - {q_sel[SAMPLE_BITS-1], q_sel};
    assign mag_wide = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;

    // Saturate the distance at the top of the accumulator range.
    assign sum      = {1'b0, acc_reg} + {1'b0, ACC_W'(sq3_reg)};
    assign acc_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (q_load)
        begin
            q_reg <= query;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            row_done4_reg <= 1'b0;
            done5_reg     <= 1'b0;
        end
        else
        begin
            tag1_reg      <= scan_tag;
            tag2_reg      <= tag1_reg;
            tag3_reg      <= tag2_reg;
            row_done4_reg <= tag3_reg.valid && tag3_reg.last_joint;
            done5_reg     <= row_done4_reg && last_row4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row1_reg   <= scan_row;
        joint1_reg <= scan_joint;
        row2_reg   <= row1_reg;
        mag2_reg   <= mag_wide[SAMPLE_BITS-1:0];
        row3_reg   <= row2_reg;
        sq3_reg    <= mag2_reg * mag2_reg;
        if (tag3_reg.valid)
        begin
            acc_reg <= tag3_reg.first_joint ? ACC_W'(sq3_reg) : acc_next;
        end
        row4_reg       <= row3_reg;
        first_row4_reg <= tag3_reg.first_row;
        last_row4_reg  <= tag3_reg.last_row;
        // Keep the first strict minimum.
        if (row_done4_reg && (first_row4_reg || (acc_reg < best_dist_reg)))
        begin
            best_dist_reg <= acc_reg;
            best_idx_reg  <= row4_reg;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_done = done5_reg;

endmodule

// ===== hw/rtl/ntps_seq.sv =====
// Sequencer: item accept, load writes, scan address walk and result read-out.
module ntps_seq
    import ntps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int JOINTS      = JOINTS_DEF,
    localparam int DEPTH      = MAX_ENTRIES * JOINTS,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int JW         = (JOINTS > 1) ? $clog2(JOINTS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     req_type,
    input  logic [9:0]               entry_index,
    input  logic [2:0]               joint_index,
    input  logic [ENTRY_COUNT_W-1:0] entry_count,
    input  logic [IW-1:0]            best_idx,
    input  logic                     best_done,
    output logic                     busy,
    output logic                     q_load,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [AW-1:0]            rd_addr,
    output scan_tag_t                scan_tag,
    output logic [IW-1:0]            scan_row,
    output logic [JW-1:0]            scan_joint,
    output emit_tag_t                emit_tag,
    output logic [JW-1:0]            emit_joint
);

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [IW-1:0] row_reg, row_next;
    logic [JW-1:0] joint_reg, joint_next;
    logic [IW-1:0] last_row_reg, last_row_next;

    logic        accept;
    logic [31:0] cnt32;
    logic [31:0] cnt_clamp;
    logic [31:0] cnt_m1;
    logic [31:0] load_addr32;
    logic [31:0] base32;
    logic        load_ok;
    logic        joint_last;

    assign accept      = start && (state_reg == ST_IDLE);
    assign cnt32       = 32'(entry_count);
    assign cnt_clamp   = (cnt32 > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : cnt32;
    assign cnt_m1      = cnt_clamp - 32'd1;
    assign load_addr32 = 32'(entry_index) * 32'(JOINTS) + 32'(joint_index);
    assign base32      = 32'(best_idx) * 32'(JOINTS);
    assign load_ok     = (32'(entry_index) < 32'(MAX_ENTRIES)) &&
                         (32'(joint_index) < 32'(JOINTS));
    assign joint_last  = (joint_reg == JW'(JOINTS - 1));

    assign busy    = (state_reg != ST_IDLE);
    assign rd_addr = addr_reg;
    assign wr_addr = load_addr32[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            row_reg      <= '0;
            joint_reg    <= '0;
            last_row_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            row_reg      <= row_next;
            joint_reg    <= joint_next;
            last_row_reg <= last_row_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        row_next      = row_reg;
        joint_next    = joint_reg;
        last_row_next = last_row_reg;
        q_load        = 1'b0;
        wr_en         = 1'b0;
        scan_tag      = '0;
        scan_row      = row_reg;
        scan_joint    = joint_reg;
        emit_tag      = '0;
        emit_joint    = joint_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        wr_en = load_ok;
                    end
                    else if (cnt32 == 32'd0)
                    begin
                        // Empty table: one flagged word, no scan.
                        emit_tag.valid = 1'b1;
                        emit_tag.empty = 1'b1;
                        emit_tag.last  = 1'b1;
                        emit_joint     = '0;
                    end
                    else
                    begin
                        q_load        = 1'b1;
                        addr_next     = '0;
                        row_next      = '0;
                        joint_next    = '0;
                        last_row_next = cnt_m1[IW-1:0];
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                scan_tag.valid       = 1'b1;
                scan_tag.first_joint = (joint_reg == '0);
                scan_tag.last_joint  = joint_last;
                scan_tag.first_row   = (row_reg == '0);
                scan_tag.last_row    = (row_reg == last_row_reg);
                addr_next            = addr_reg + 1'b1;
                if (joint_last)
                begin
                    joint_next = '0;
                    row_next   = row_reg + 1'b1;
                    if (row_reg == last_row_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    joint_next = joint_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // Hold until the last row has been compared.
                if (best_done)
                begin
                    addr_next  = base32[AW-1:0];
                    joint_next = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                emit_tag.valid = 1'b1;
                emit_tag.last  = joint_last;
                addr_next      = addr_reg + 1'b1;
                if (joint_last)
                begin
                    joint_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    joint_next = joint_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nearest_trajectory_point_search.sv =====
// Load item: written without raising busy. Query: busy while it scans and reads out; the
// result words come one word a cycle once the scan has drained.
// count is entry_count capped at MAX_ENTRIES; the single shared subtract-square-
// accumulate unit and the one memory read port handle one joint sample per cycle.
// Empty table: one flagged word on the cycle after accept; busy does not rise.
// Reset clears the sequencer and entry_count; the table memories are not cleared.
module nearest_trajectory_point_search
    import ntps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int JOINTS      = JOINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  in_word_t           request,
    output logic               busy,
    output logic               result_valid,
    output out_word_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH = MAX_ENTRIES * JOINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic [ENTRY_COUNT_W-1:0] entry_count_reg;

    logic                               q_load;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      rd_addr;
    logic [SAMPLE_BITS-1:0]             rd_mean;
    logic [SAMPLE_BITS-1:0]             rd_spread;
    logic [SAMPLE_BITS-1:0]             wr_mean;
    logic [SAMPLE_BITS-1:0]             wr_spread;
    logic [JOINTS-1:0][SAMPLE_BITS-1:0] query;
    logic [6:0][19:0]                   angles;
    scan_tag_t                          scan_tag;
    logic [IW-1:0]                      scan_row;
    logic [JW-1:0]                      scan_joint;
    emit_tag_t                          emit_tag;
    logic [JW-1:0]                      emit_joint;
    logic [IW-1:0]                      best_idx;
    logic                               best_done;

    emit_tag_t     emit_d_reg;
    logic [JW-1:0] emit_joint_d_reg;

    logic [31:0] mean_ext;
    logic [31:0] spread_ext;
    logic [31:0] idx_ext;

    // Configuration register: a single word; paddr is not decoded, so every offset reaches it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            entry_count_reg <= pwdata[ENTRY_COUNT_W-1:0];
        end
    end

    assign prdata = PDATA_W'(entry_count_reg);
    assign pready = 1'b1;

    assign angles = {request.angle_6, request.angle_5, request.angle_4, request.angle_3,
                     request.angle_2, request.angle_1, request.angle_0};

    for (genvar g = 0; g < JOINTS; g++)
    begin : g_query
        assign query[g] = SAMPLE_BITS'(sext20(angles[g]));
    end

    assign wr_mean   = SAMPLE_BITS'(sext20(request.mean_value));
    assign wr_spread = SAMPLE_BITS'(32'(request.std_value));

    ntps_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .JOINTS      (JOINTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (request.req_type),
        .entry_index (request.entry_index),
        .joint_index (request.joint_index),
        .entry_count (entry_count_reg),
        .best_idx    (best_idx),
        .best_done   (best_done),
        .busy        (busy),
        .q_load      (q_load),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .scan_tag    (scan_tag),
        .scan_row    (scan_row),
        .scan_joint  (scan_joint),
        .emit_tag    (emit_tag),
        .emit_joint  (emit_joint)
    );

    ntps_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_mean   (wr_mean),
        .wr_spread (wr_spread),
        .rd_addr   (rd_addr),
        .rd_mean   (rd_mean),
        .rd_spread (rd_spread)
    );

    ntps_dist_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .JOINTS      (JOINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_load     (q_load),
        .query      (query),
        .scan_tag   (scan_tag),
        .scan_row   (scan_row),
        .scan_joint (scan_joint),
        .rd_mean    (rd_mean),
        .best_idx   (best_idx),
        .best_done  (best_done)
    );

    // Align the word tag with the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_d_reg <= '0;
        end
        else
        begin
            emit_d_reg <= emit_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_joint_d_reg <= emit_joint;
    end

    assign mean_ext   = 32'($signed(rd_mean));
    assign spread_ext = 32'(rd_spread);
    assign idx_ext    = 32'(best_idx);

    always_comb
    begin
        result_valid        = emit_d_reg.valid;
        result.empty_table  = emit_d_reg.empty;
        result.last_of_run  = emit_d_reg.last;
        if (emit_d_reg.empty)
        begin
            result.result_joint = '0;
            result.nearest_mean = '0;
            result.nearest_std  = '0;
            result.match_index  = '0;
        end
        else
        begin
            result.result_joint = 3'(emit_joint_d_reg);
            result.nearest_mean = mean_ext[19:0];
            result.nearest_std  = spread_ext[18:0];
            result.match_index  = idx_ext[9:0];
        end
    end

endmodule

// ===== verif/ntps_checker.sv =====
// Checker for the nearest trajectory point search: tracks table and count, predicts result words.
module ntps_checker
    import ntps_pkg::*;
#(
    parameter logic [PADDR_W-1:0] COUNT_ADDR = '0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  in_word_t           request,
    input  logic               result_valid,
    input  out_word_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    logic signed [19:0]       mean_tab [MAX_ENTRIES_DEF][JOINTS_DEF];
    logic [18:0]              std_tab  [MAX_ENTRIES_DEF][JOINTS_DEF];
    logic [ENTRY_COUNT_W-1:0] count_reg;
    out_word_t                nearest_q [$];
    out_word_t                head;

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Scan the searched entries and queue the words of the first strict minimum.
    function automatic void search_nearest(input in_word_t w);
        int                 n;
        int                 best;
        int                 diff;
        longint             row_dist;
        longint             best_dist;
        logic signed [19:0] ang [JOINTS_DEF];
        out_word_t          r;
        n = (count_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(count_reg);
        if (n == 0)
        begin
            r = '0;
            r.empty_table = 1'b1;
            r.last_of_run = 1'b1;
            nearest_q.push_back(r);
        end
        else
        begin
            ang[0] = w.angle_0;
            ang[1] = w.angle_1;
            ang[2] = w.angle_2;
            ang[3] = w.angle_3;
            ang[4] = w.angle_4;
            ang[5] = w.angle_5;
            ang[6] = w.angle_6;
            best = 0;
            best_dist = 0;
            // 20-bit samples keep the sum far below 64 bits, so no saturation
            for (int i = 0; i < n; i++)
            begin
                row_dist = 0;
                for (int j = 0; j < JOINTS_DEF; j++)
                begin
                    diff = int'(mean_tab[i][j]) - int'(ang[j]);
                    row_dist += longint'(diff) * longint'(diff);
                end
                if (i == 0 || row_dist < best_dist)
                begin
                    best = i;
                    best_dist = row_dist;
                end
            end
            for (int j = 0; j < JOINTS_DEF; j++)
            begin
                r.result_joint = 3'(j);
                r.nearest_mean = mean_tab[best][j];
                r.nearest_std  = std_tab[best][j];
                r.match_index  = 10'(best);
                r.empty_table  = 1'b0;
                r.last_of_run  = (j == JOINTS_DEF - 1);
                nearest_q.push_back(r);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            count_reg = '0;
            nearest_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("result word with nothing expected: joint %0d index %0d",
                           result.result_joint, result.match_index);
                    errors++;
                end
                else
                begin
                    head = nearest_q.pop_front();
                    check_field("result_joint", head.result_joint, result.result_joint);
                    check_field("nearest_mean", head.nearest_mean, result.nearest_mean);
                    check_field("nearest_std", head.nearest_std, result.nearest_std);
                    check_field("match_index", head.match_index, result.match_index);
                    check_field("empty_table", head.empty_table, result.empty_table);
                    check_field("last_of_run", head.last_of_run, result.last_of_run);
                end
            end
            if (start && !busy)
            begin
                if (request.req_type == REQ_QUERY)
                    search_nearest(request);
                else if (request.joint_index < JOINTS_DEF)
                begin
                    mean_tab[request.entry_index][request.joint_index] = request.mean_value;
                    std_tab[request.entry_index][request.joint_index]  = request.std_value;
                end
            end
            if (psel && penable && pready && paddr == COUNT_ADDR)
            begin
                if (pwrite)
                    count_reg = pwdata[ENTRY_COUNT_W-1:0];
                else
                    check_field("entry_count", count_reg, prdata[ENTRY_COUNT_W-1:0]);
            end
        end
        pending = nearest_q.size();
    end

endmodule

// ===== verif/nearest_trajectory_point_search_tb.sv =====
// Testbench top for the nearest trajectory point search: clock, reset, stimulus and verdict.
module nearest_trajectory_point_search_tb;
    import ntps_pkg::*;

    localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = '0;
    localparam int QUIET_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_TAIL    = 60;
    localparam int MEAN_MAX     = 524287;
    localparam int MEAN_MIN     = -524288;

    logic               clk;
    logic               rst_n;
    logic               start;
    in_word_t           request;
    logic               busy;
    logic               result_valid;
    out_word_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 errors;
    int                 pending;
    int                 quiet_cycles;
    bit                 idle_on;
    logic signed [19:0] mean_shadow [MAX_ENTRIES_DEF][JOINTS_DEF];

    nearest_trajectory_point_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ntps_checker #(
        .COUNT_ADDR (ENTRY_COUNT_ADDR)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_word_t random_word();
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return in_word_t'(bits[$bits(in_word_t)-1:0]);
    endfunction

    function automatic in_word_t load_word(input int e, input int j, input int m, input int s);
        in_word_t w;
        w = random_word();
        w.req_type    = REQ_LOAD;
        w.entry_index = 10'(e);
        w.joint_index = 3'(j);
        w.mean_value  = 20'(m);
        w.std_value   = 19'(s);
        return w;
    endfunction

    function automatic in_word_t with_angles(input logic [JOINTS_DEF-1:0][19:0] a);
        in_word_t w;
        w = random_word();
        w.req_type = REQ_QUERY;
        w.angle_0  = a[0];
        w.angle_1  = a[1];
        w.angle_2  = a[2];
        w.angle_3  = a[3];
        w.angle_4  = a[4];
        w.angle_5  = a[5];
        w.angle_6  = a[6];
        return w;
    endfunction

    // Aim a query at an entry's means, jittered by up to span and clamped to range.
    function automatic in_word_t query_near(input int e, input int span);
        logic [JOINTS_DEF-1:0][19:0] a;
        int                          v;
        for (int j = 0; j < JOINTS_DEF; j++)
        begin
            v = int'(mean_shadow[e][j]) + int'($urandom_range(0, 2 * span)) - span;
            if (v > MEAN_MAX)
                v = MEAN_MAX;
            if (v < MEAN_MIN)
                v = MEAN_MIN;
            a[j] = 20'(v);
        end
        return with_angles(a);
    endfunction

    function automatic in_word_t query_flat(input int v);
        logic [JOINTS_DEF-1:0][19:0] a;
        for (int j = 0; j < JOINTS_DEF; j++)
            a[j] = 20'(v);
        return with_angles(a);
    endfunction

    function automatic in_word_t query_random();
        in_word_t w;
        w = random_word();
        w.req_type = REQ_QUERY;
        return w;
    endfunction

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Called and returns at a falling edge; hold the word until it is taken.
    task automatic send_word(input in_word_t w);
        if (idle_on && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 3));
        start   <= 1'b1;
        request <= w;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        if (w.req_type == REQ_LOAD && w.joint_index < JOINTS_DEF)
            mean_shadow[w.entry_index][w.joint_index] = w.mean_value;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input int data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= PDATA_W'(data);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_entry_count(input int n);
        drain();
        apb_access(1'b1, n);
        apb_access(1'b0, 0);
    endtask

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int sent;
        int pick;
        int cnt;
        int span;
        int n;
        int r;
        int e;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // count is zero out of reset: empty table
        send_word(query_random());
        start <= 1'b0;
        apb_access(1'b0, 0);

        // Fill every entry so no query can touch an unwritten slot.
        for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        begin
            for (int j = 0; j < JOINTS_DEF; j++)
            begin
                if (i == 0)
                    send_word(load_word(i, j, MEAN_MAX, MEAN_MAX));
                else if (i == 1)
                    send_word(load_word(i, j, MEAN_MIN, 0));
                else if (i == 3)
                    send_word(load_word(i, j, mean_shadow[2][j], $urandom));
                else
                    send_word(load_word(i, j, $urandom, $urandom));
            end
        end

        set_entry_count(1);
        send_word(query_random());
        set_entry_count(4);
        send_word(query_flat(MEAN_MAX));
        send_word(query_flat(MEAN_MIN));
        // entries 2 and 3 tie: the first one wins
        send_word(query_near(2, 0));
        // joint slot out of range must not spill into the next entry
        send_word(load_word(1, JOINTS_DEF, $urandom, $urandom));
        send_word(query_near(2, 0));
        send_word(load_word(2, 0, $urandom, $urandom));
        send_word(query_near(3, 0));
        set_entry_count(0);
        send_word(query_near(0, 0));
        set_entry_count(MAX_ENTRIES_DEF);
        send_word(query_near(MAX_ENTRIES_DEF - 1, 0));
        set_entry_count((1 << ENTRY_COUNT_W) - 1);
        send_word(query_random());

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                cnt = 0;
            else if (pick == 1)
                cnt = $urandom_range(MAX_ENTRIES_DEF, (1 << ENTRY_COUNT_W) - 1);
            else
                cnt = $urandom_range(1, 32);
            set_entry_count(cnt);
            span = (cnt > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cnt;
            n = (pick == 1) ? 3 : $urandom_range(10, 25);
            repeat (n)
            begin
                idle_on = (sent < RANDOM_ITEMS - CALM_TAIL);
                r = $urandom_range(0, 99);
                if (r < 55 && span > 0)
                    send_word(query_near($urandom_range(0, span - 1),
                                         1 << $urandom_range(0, 14)));
                else if (r < 70)
                    send_word(query_random());
                else if (r < 75)
                    send_word(query_flat($urandom_range(0, 1) ? MEAN_MAX : MEAN_MIN));
                else
                begin
                    if (span > 0 && $urandom_range(0, 1))
                        e = $urandom_range(0, span - 1);
                    else
                        e = $urandom_range(0, MAX_ENTRIES_DEF - 1);
                    send_word(load_word(e, $urandom_range(0, 7), $urandom, $urandom));
                end
                sent++;
                // hold off until every queued word is out
                if (sent == RANDOM_ITEMS / 2)
                    drain();
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== nearest_trajectory_point_search.f =====
hw/rtl/ntps_pkg.sv
hw/rtl/ntps_store.sv
hw/rtl/ntps_dist_unit.sv
hw/rtl/ntps_seq.sv
hw/rtl/nearest_trajectory_point_search.sv
verif/ntps_checker.sv
verif/nearest_trajectory_point_search_tb.sv
